// ===== rtl/smt_lex_pkg.sv =====
// Shared types, character constants and classification functions for the
// SMT-LIB v2 token lexer. No dependencies; every other file imports this package.
package smt_lex_pkg;

  // Width of the saturating line counter.
  localparam int LINE_BITS = 32;

  // A single request never produces more than two results: a token
  // completion followed by the reprocessed byte's own event or by the EOF
  // token, or the two prefix bytes of a #b / #x numeral.
  localparam int MaxRes = 2;
  localparam int ResCntBits = $clog2(MaxRes + 1);

  // Depth of the result queue in front of the output port.
  localparam int QDepth = 4;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int QCntBits = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    EV_TEXT  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } lex_event_t;

  typedef enum logic [2:0] {
    TK_SYMBOL  = 3'd0,
    TK_KEYWORD = 3'd1,
    TK_NUMERAL = 3'd2,
    TK_STRING  = 3'd3,
    TK_OPEN    = 3'd4,
    TK_CLOSE   = 3'd5,
    TK_EOF     = 3'd6
  } lex_kind_t;

  typedef enum logic [2:0] {
    ER_BAD_CHAR   = 3'd0,
    ER_BAD_HASH   = 3'd1,
    ER_EOF_HASH   = 3'd2,
    ER_EOF_QUOTED = 3'd3,
    ER_EOF_STRING = 3'd4,
    ER_EMPTY_KW   = 3'd5
  } lex_err_t;

  typedef enum logic [0:0] {
    ACT_BYTE = 1'b0,
    ACT_EOF  = 1'b1
  } lex_action_t;

  typedef enum logic [10:0] {
    M_IDLE    = 11'b000_0000_0001,
    M_COMMENT = 11'b000_0000_0010,
    M_SYMBOL  = 11'b000_0000_0100,
    M_KEYWORD = 11'b000_0000_1000,
    M_DECIMAL = 11'b000_0001_0000,
    M_HASH    = 11'b000_0010_0000,
    M_BIN     = 11'b000_0100_0000,
    M_HEX     = 11'b000_1000_0000,
    M_QUOTED  = 11'b001_0000_0000,
    M_STRING  = 11'b010_0000_0000,
    M_STRQ    = 11'b100_0000_0000
  } lex_mode_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NBSP   = 8'hA0;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;

  // One result as it leaves the block.
  typedef struct packed {
    lex_event_t  event_res;
    lex_kind_t   token_kind;
    logic        quoted;
    logic [7:0]  text_byte;
    logic [31:0] line_number;
    lex_err_t    error_code;
    logic        last;
  } lex_res_t;

  // Results of one request, handed from the step logic to the queue.
  typedef struct packed {
    logic [ResCntBits-1:0]    count;
    lex_res_t [MaxRes-1:0]    res;
  } lex_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Simple-symbol characters: letters, digits and ~!@$%^&*_-+=<>.?/
  function automatic logic is_sym(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                      8'h7E, 8'h21, 8'h40, 8'h24, 8'h25, 8'h5E, 8'h26,
                      8'h2A, 8'h5F, 8'h2D, 8'h2B, 8'h3D, 8'h3C, 8'h3E,
                      8'h2E, 8'h3F, 8'h2F});
  endfunction

  function automatic lex_res_t mk_text(input logic [7:0] b);
    lex_res_t r;
    r = '0;
    r.event_res = EV_TEXT;
    r.text_byte = b;
    return r;
  endfunction

  function automatic lex_res_t mk_done(input lex_kind_t k, input logic q,
                                       input logic [31:0] line);
    lex_res_t r;
    r = '0;
    r.event_res   = EV_DONE;
    r.token_kind  = k;
    r.quoted      = q;
    r.line_number = line;
    return r;
  endfunction

  function automatic lex_res_t mk_err(input lex_err_t e, input logic [31:0] line);
    lex_res_t r;
    r = '0;
    r.event_res   = EV_ERROR;
    r.error_code  = e;
    r.line_number = line;
    return r;
  endfunction

endpackage

// ===== rtl/smt_lex_if.sv =====
// Valid/ready channel interfaces for the lexer's request and result sides.
// Depends on smt_lex_pkg for the payload types.
interface smt_lex_in_if;
  import smt_lex_pkg::*;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  in_byte;

  modport source (output valid, action, in_byte, input ready);
  modport sink   (input valid, action, in_byte, output ready);
endinterface

interface smt_lex_out_if;
  import smt_lex_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [2:0]  token_kind;
  logic        quoted;
  logic [7:0]  text_byte;
  logic [31:0] line_number;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, event_res, token_kind, quoted, text_byte,
                  line_number, error_code, last, input ready);
  modport sink   (input valid, event_res, token_kind, quoted, text_byte,
                  line_number, error_code, last, output ready);
endinterface

// ===== rtl/smt_lex_step.sv =====
// Lexer state registers and the single-pass step logic for one request.
// Depends on smt_lex_pkg.
module smt_lex_step import smt_lex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic       action,
  input  logic [7:0] in_byte,
  output lex_push_t  push
);

  lex_mode_t            mode_r, mode_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 kw_r, kw_nxt;
  logic                 halt_r, halt_nxt;

  logic [31:0]          line_out;
  logic                 line_inc;
  logic                 redo;
  logic [ResCntBits-1:0] n;
  lex_res_t [MaxRes-1:0] res_v;

  assign line_out = 32'(line_r);

  always_comb begin
    mode_nxt = mode_r;
    kw_nxt   = kw_r;
    halt_nxt = halt_r;
    line_inc = 1'b0;
    redo     = 1'b0;
    n        = '0;
    res_v    = '0;

    if (!halt_r) begin
      if (action == ACT_EOF) begin
        case (mode_r)
          M_SYMBOL: begin
            res_v[n[0]] = mk_done(TK_SYMBOL, 1'b0, line_out); n = n + 1'b1;
          end
          M_DECIMAL, M_BIN, M_HEX: begin
            res_v[n[0]] = mk_done(TK_NUMERAL, 1'b0, line_out); n = n + 1'b1;
          end
          M_STRQ: begin
            res_v[n[0]] = mk_done(TK_STRING, 1'b0, line_out); n = n + 1'b1;
          end
          M_KEYWORD: begin
            if (!kw_r) begin
              res_v[n[0]] = mk_err(ER_EMPTY_KW, line_out); n = n + 1'b1;
              halt_nxt = 1'b1;
            end else begin
              res_v[n[0]] = mk_done(TK_KEYWORD, 1'b0, line_out); n = n + 1'b1;
            end
          end
          M_HASH: begin
            res_v[n[0]] = mk_err(ER_EOF_HASH, line_out); n = n + 1'b1;
            halt_nxt = 1'b1;
          end
          M_QUOTED: begin
            res_v[n[0]] = mk_err(ER_EOF_QUOTED, line_out); n = n + 1'b1;
            halt_nxt = 1'b1;
          end
          M_STRING: begin
            res_v[n[0]] = mk_err(ER_EOF_STRING, line_out); n = n + 1'b1;
            halt_nxt = 1'b1;
          end
          default: begin
          end
        endcase
        if (!halt_nxt) begin
          mode_nxt = M_IDLE;
          res_v[n[0]] = mk_done(TK_EOF, 1'b0, line_out); n = n + 1'b1;
        end
      end else begin
        case (mode_r)
          M_COMMENT: begin
            if (in_byte == CH_NL) begin
              line_inc = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_SYMBOL: begin
            if (is_sym(in_byte)) begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
            end else begin
              res_v[n[0]] = mk_done(TK_SYMBOL, 1'b0, line_out); n = n + 1'b1;
              redo = 1'b1;
            end
          end
          M_KEYWORD: begin
            if (is_sym(in_byte)) begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
              kw_nxt = 1'b1;
            end else if (!kw_r) begin
              res_v[n[0]] = mk_err(ER_EMPTY_KW, line_out); n = n + 1'b1;
              halt_nxt = 1'b1;
            end else begin
              res_v[n[0]] = mk_done(TK_KEYWORD, 1'b0, line_out); n = n + 1'b1;
              redo = 1'b1;
            end
          end
          M_DECIMAL: begin
            if (is_digit(in_byte) || in_byte == CH_DOT) begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
            end else begin
              res_v[n[0]] = mk_done(TK_NUMERAL, 1'b0, line_out); n = n + 1'b1;
              redo = 1'b1;
            end
          end
          M_HASH: begin
            if (in_byte == CH_LOW_B || in_byte == CH_LOW_X) begin
              res_v[0] = mk_text(CH_HASH);
              res_v[1] = mk_text(in_byte);
              n = 2'(MaxRes);
              mode_nxt = (in_byte == CH_LOW_B) ? M_BIN : M_HEX;
            end else begin
              res_v[n[0]] = mk_err(ER_BAD_HASH, line_out); n = n + 1'b1;
              halt_nxt = 1'b1;
            end
          end
          M_BIN: begin
            if (in_byte == CH_ZERO || in_byte == CH_ONE) begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
            end else begin
              res_v[n[0]] = mk_done(TK_NUMERAL, 1'b0, line_out); n = n + 1'b1;
              redo = 1'b1;
            end
          end
          M_HEX: begin
            if (is_hex(in_byte)) begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
            end else begin
              res_v[n[0]] = mk_done(TK_NUMERAL, 1'b0, line_out); n = n + 1'b1;
              redo = 1'b1;
            end
          end
          M_QUOTED: begin
            if (in_byte == CH_BAR) begin
              res_v[n[0]] = mk_done(TK_SYMBOL, 1'b1, line_out); n = n + 1'b1;
              mode_nxt = M_IDLE;
            end else begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
              line_inc = (in_byte == CH_NL);
            end
          end
          M_STRING: begin
            if (in_byte == CH_DQUOTE) begin
              mode_nxt = M_STRQ;
            end else begin
              res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
            end
          end
          M_STRQ: begin
            if (in_byte == CH_DQUOTE) begin
              res_v[n[0]] = mk_text(CH_DQUOTE); n = n + 1'b1;
              mode_nxt = M_STRING;
            end else begin
              res_v[n[0]] = mk_done(TK_STRING, 1'b0, line_out); n = n + 1'b1;
              redo = 1'b1;
            end
          end
          default: redo = 1'b1;
        endcase

        // The byte that ended a token is looked at again as the first byte
        // after it, with the idle-mode rules.
        if (redo) begin
          mode_nxt = M_IDLE;
          case (in_byte)
            CH_NL: line_inc = 1'b1;
            CH_SPACE, CH_CR, CH_TAB, CH_NBSP: begin
            end
            CH_SEMI: mode_nxt = M_COMMENT;
            CH_LPAREN: begin
              res_v[n[0]] = mk_done(TK_OPEN, 1'b0, line_out); n = n + 1'b1;
            end
            CH_RPAREN: begin
              res_v[n[0]] = mk_done(TK_CLOSE, 1'b0, line_out); n = n + 1'b1;
            end
            CH_BAR:    mode_nxt = M_QUOTED;
            CH_DQUOTE: mode_nxt = M_STRING;
            CH_COLON: begin
              mode_nxt = M_KEYWORD;
              kw_nxt   = 1'b0;
            end
            CH_HASH: mode_nxt = M_HASH;
            default: begin
              if (is_digit(in_byte)) begin
                res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
                mode_nxt = M_DECIMAL;
              end else if (is_sym(in_byte)) begin
                res_v[n[0]] = mk_text(in_byte); n = n + 1'b1;
                mode_nxt = M_SYMBOL;
              end else begin
                res_v[n[0]] = mk_err(ER_BAD_CHAR, line_out); n = n + 1'b1;
                halt_nxt = 1'b1;
              end
            end
          endcase
        end
      end
    end

    // Flag the final result of this request.
    if (n != '0) begin
      res_v[n == 2'(MaxRes)].last = 1'b1;
    end
  end

  // Every emit above reports the line as it was before this request.
  assign line_nxt = (line_inc && line_r != '1) ? line_r + 1'b1 : line_r;

  assign push.count = n;
  assign push.res   = res_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= LINE_BITS'(1);
      kw_r   <= 1'b0;
      halt_r <= 1'b0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      kw_r   <= kw_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== rtl/smt_lex_outq.sv =====
// Result queue: takes up to two results per cycle, hands one per cycle to
// the output channel while it is ready. Depends on smt_lex_pkg and smt_lex_if.
module smt_lex_outq import smt_lex_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en,
  input  lex_push_t        push,
  output logic             has_room,
  smt_lex_out_if.source    out_chan
);

  lex_res_t              q_mem [QDepth];
  logic [QPtrBits-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrBits-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntBits-1:0]   cnt_r, cnt_nxt;
  logic                  pop;
  logic [ResCntBits-1:0] push_n;
  lex_res_t              head;

  assign push_n   = push_en ? push.count : '0;
  assign has_room = (cnt_r <= QCntBits'(QDepth - MaxRes));
  assign pop      = (cnt_r != '0) && out_chan.ready;

  assign wr_ptr_nxt = wr_ptr_r + QPtrBits'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + QPtrBits'(pop);
  assign cnt_nxt    = cnt_r + QCntBits'(push_n) - QCntBits'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (ResCntBits'(i) < push_n) begin
        q_mem[wr_ptr_r + QPtrBits'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head = q_mem[rd_ptr_r];

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.event_res   = head.event_res;
  assign out_chan.token_kind  = head.token_kind;
  assign out_chan.quoted      = head.quoted;
  assign out_chan.text_byte   = head.text_byte;
  assign out_chan.line_number = head.line_number;
  assign out_chan.error_code  = head.error_code;
  assign out_chan.last        = head.last;

endmodule

// ===== rtl/smt_lib_token_lexer_unit.sv =====
// Top level of the SMT-LIB v2 token lexer: input register, step logic and
// result queue. Depends on smt_lex_pkg, smt_lex_if, smt_lex_step, smt_lex_outq.
// A request goes from the input register into the result queue, where its first
// result waits to be taken. Throughput: one request per cycle while each yields
// at most one result and out_chan is ready; results leave one per cycle on ready.
// Reset (rst_n, synchronous, active low): idle mode, line 1, not halted, queue empty.
module smt_lib_token_lexer_unit import smt_lex_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  smt_lex_in_if.sink    in_chan,
  smt_lex_out_if.source out_chan
);

  // The input register holds one request. It is handed to the step logic
  // and its results go into the queue in the same cycle, as long as the
  // queue can take the largest burst a request can produce. A new request
  // is taken whenever the register is empty or is being drained.
  logic       in_v_r;
  logic       in_action_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       room;
  lex_push_t  push;

  assign advance       = in_v_r && room;
  assign in_chan.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  // Payload needs no reset; it is only looked at while in_v_r is set.
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_action_r <= in_chan.action;
      in_byte_r   <= in_chan.in_byte;
    end
  end

  // Mode, line counter and halt flag live in the step block and advance
  // only when a request is handed over. A halted lexer still consumes
  // requests but produces no results.
  smt_lex_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .action  (in_action_r),
    .in_byte (in_byte_r),
    .push    (push)
  );

  // The queue decouples the two sides so a stalled consumer does not stop
  // requests from being taken until the queue fills.
  smt_lex_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (advance),
    .push     (push),
    .has_room (room),
    .out_chan (out_chan)
  );

endmodule
